[rtl/magic_length_frame_deframer_core_macros.svh]
// Assertion helpers used by the deframer core RTL file.
`ifndef MAGIC_LENGTH_FRAME_DEFRAMER_CORE_MACROS_SVH
`define MAGIC_LENGTH_FRAME_DEFRAMER_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MLFD_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define MLFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/mlfd_pkg.sv]
package mlfd_pkg;

  localparam int BUFFER_BYTES_DEF = 64;
  localparam int HEADER_BYTES     = 6;
  localparam int CNT_W            = 7;
  localparam int LEN_W            = 6;
  localparam int OUT_DATA_W       = 48;
  localparam int ADDR_W           = 4;

  // Byte positions inside the frame header.
  localparam int HDR_VERSION = 2;
  localparam int HDR_TYPE    = 3;
  localparam int HDR_LEN_LO  = 4;
  localparam int HDR_LEN_HI  = 5;

  // Register indexes (paddr[3:2]).
  localparam logic [1:0] REG_MAGIC_FIRST  = 2'd0;
  localparam logic [1:0] REG_MAGIC_SECOND = 2'd1;
  localparam logic [1:0] REG_MAX_LEN      = 2'd2;

  localparam logic [7:0]       MAGIC_FIRST_RST  = 8'hAA;
  localparam logic [7:0]       MAGIC_SECOND_RST = 8'h55;
  localparam logic [LEN_W-1:0] MAX_LEN_RST      = 6'd58;

  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_CLEAR   = 1'b1;
  localparam logic RK_PAYLOAD   = 1'b0;
  localparam logic RK_ERROR     = 1'b1;
  localparam logic ERR_OVERFLOW = 1'b0;
  localparam logic ERR_LENGTH   = 1'b1;

  // Result data word, last member in the lowest bits.
  typedef struct packed {
    logic [3:0]       pad;
    logic [CNT_W-1:0] buffered_count;
    logic [7:0]       payload_byte;
    logic [LEN_W-1:0] payload_index;
    logic [LEN_W-1:0] payload_length;
    logic [7:0]       message_type;
    logic [7:0]       frame_version;
    logic             error_code;
  } out_data_t;

endpackage

[rtl/mlfd_ring.sv]
module mlfd_ring #(
  parameter int BUFFER_BYTES = mlfd_pkg::BUFFER_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                wr_en,
  input  logic [$clog2(BUFFER_BYTES)-1:0]     head,
  input  logic [$clog2(BUFFER_BYTES+1)-1:0]   offset,
  input  logic [7:0]                          wr_data,
  output logic [7:0]                          rd_data
);
  import mlfd_pkg::*;

  localparam int PW = $clog2(BUFFER_BYTES);
  localparam int CW = $clog2(BUFFER_BYTES + 1);

  logic [7:0]    mem [BUFFER_BYTES];
  logic [CW:0]   sum;
  logic [PW-1:0] addr;

  // The ring position is head plus offset, wrapped once at the buffer size.
  always_comb begin
    sum = (CW+1)'(head) + (CW+1)'(offset);
    if (sum >= (CW+1)'(BUFFER_BYTES)) begin
      sum = sum - (CW+1)'(BUFFER_BYTES);
    end
    addr = sum[PW-1:0];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    rd_data <= mem[addr];
  end

endmodule

[rtl/magic_length_frame_deframer_core.sv]
// Channel   Direction  Handshake          Payload
// s_*       in         s_tvalid/s_tready  tuser kind, tdata data_byte
// m_*       out        m_tvalid/m_tready  tuser result_kind, tlast last_item, tdata fields
// apb       in/out     psel/penable/pready  register writes and reads
//
// A clear request empties the ring in the idle state. A received byte is written, then the
// parser scans the ring through one registered read port: S_SCAN_RD and S_SCAN_CHK per byte
// searched for the magic pair, S_HDR_RD and S_HDR_CHK per header byte. Output stalls hold S_EMIT.
// A step that produces results is parsed twice (the first pass finds the final fill
// level); the second pass runs S_PAY_RD, S_PAY_CHK and S_EMIT per payload item, S_EMIT only
// for an error report or empty frame. Reset empties the ring at once; there is no clearing pass.
`include "magic_length_frame_deframer_core_macros.svh"

module magic_length_frame_deframer_core #(
  parameter int BUFFER_BYTES = mlfd_pkg::BUFFER_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,   // [7:0] data_byte
  input  logic                              s_tuser,   // [0] kind
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [0] error_code, [8:1] frame_version, [16:9] message_type, [22:17] payload_length,
  // [28:23] payload_index, [36:29] payload_byte, [43:37] buffered_count, [47:44] zero
  output logic [mlfd_pkg::OUT_DATA_W-1:0]   m_tdata,
  output logic                              m_tuser,   // [0] result_kind
  output logic                              m_tlast,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mlfd_pkg::ADDR_W-1:0]       paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import mlfd_pkg::*;

  localparam int PW = $clog2(BUFFER_BYTES);
  localparam int CW = $clog2(BUFFER_BYTES + 1);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SCAN_RD  = 4'd1;
  localparam logic [3:0] S_SCAN_CHK = 4'd2;
  localparam logic [3:0] S_HDR_RD   = 4'd3;
  localparam logic [3:0] S_HDR_CHK  = 4'd4;
  localparam logic [3:0] S_PAY_RD   = 4'd5;
  localparam logic [3:0] S_PAY_CHK  = 4'd6;
  localparam logic [3:0] S_EMIT     = 4'd7;
  localparam logic [3:0] S_END      = 4'd8;

  localparam logic [1:0] EK_PAY = 2'd0;
  localparam logic [1:0] EK_LEN = 2'd1;
  localparam logic [1:0] EK_OVF = 2'd2;

  logic [3:0]       state, state_next;
  logic [PW-1:0]    head, head_next, save_head, save_head_next;
  logic [CW-1:0]    count, count_next, save_count, save_count_next;
  logic [CW-1:0]    final_count, final_count_next;
  logic             pass, pass_next, any_hit, any_hit_next;
  logic [CW-1:0]    off, off_next;
  logic [7:0]       prev_byte, prev_byte_next;
  logic [7:0]       ver, ver_next, mt, mt_next, lo_byte, lo_byte_next, pbyte, pbyte_next;
  logic [LEN_W-1:0] plen, plen_next, pidx, pidx_next;
  logic [1:0]       ek, ek_next;
  logic [7:0]       magic_first, magic_second;
  logic [LEN_W-1:0] max_len;

  logic             drop_en, load_out, wr_en, accept;
  logic [CW-1:0]    drop_n, ring_off, pay_off;
  logic [CW:0]      head_sum;
  logic [PW-1:0]    head_drop;
  logic [7:0]       rd_data;
  logic [CNT_W-1:0] flen_lo, flen_q;
  logic             len_bad;

  out_data_t        out_q;
  logic             m_tvalid_q, m_tuser_q, m_tlast_q;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign wr_en    = accept && (s_tuser == KIND_BYTE) && (count != CW'(BUFFER_BYTES));
  assign pay_off  = CW'(CNT_W'(HEADER_BYTES) + CNT_W'(pidx));
  assign ring_off = (state == S_IDLE) ? count : ((state == S_PAY_RD) ? pay_off : off);
  assign flen_lo  = CNT_W'(HEADER_BYTES) + CNT_W'(lo_byte[LEN_W-1:0]);
  assign flen_q   = CNT_W'(HEADER_BYTES) + CNT_W'(plen);
  assign len_bad  = (rd_data != 8'd0) || (lo_byte > {2'b00, max_len});

  mlfd_ring #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_ring (
    .clk    (clk),
    .wr_en  (wr_en),
    .head   (head),
    .offset (ring_off),
    .wr_data(s_tdata),
    .rd_data(rd_data)
  );

  // Dropping bytes from the front only moves the head pointer around the ring.
  always_comb begin
    head_sum = (CW+1)'(head) + (CW+1)'(drop_n);
    if (head_sum >= (CW+1)'(BUFFER_BYTES)) begin
      head_sum = head_sum - (CW+1)'(BUFFER_BYTES);
    end
    head_drop = head_sum[PW-1:0];
  end

  always_comb begin
    state_next       = state;
    head_next        = head;
    count_next       = count;
    save_head_next   = save_head;
    save_count_next  = save_count;
    final_count_next = final_count;
    pass_next        = pass;
    any_hit_next     = any_hit;
    off_next         = off;
    prev_byte_next   = prev_byte;
    ver_next         = ver;
    mt_next          = mt;
    lo_byte_next     = lo_byte;
    pbyte_next       = pbyte;
    plen_next        = plen;
    pidx_next        = pidx;
    ek_next          = ek;
    drop_en          = 1'b0;
    drop_n           = '0;
    load_out         = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser == KIND_CLEAR) begin
            count_next = '0;
          end else if (count == CW'(BUFFER_BYTES)) begin
            count_next       = '0;
            final_count_next = '0;
            ek_next          = EK_OVF;
            state_next       = S_EMIT;
          end else begin
            count_next      = count + CW'(1);
            save_head_next  = head;
            save_count_next = count + CW'(1);
            pass_next       = 1'b0;
            any_hit_next    = 1'b0;
            off_next        = '0;
            state_next      = S_SCAN_RD;
          end
        end
      end
      S_SCAN_RD: begin
        state_next = (count == '0) ? S_END : S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (off != '0 && prev_byte == magic_first && rd_data == magic_second) begin
          drop_en    = 1'b1;
          drop_n     = off - CW'(1);
          off_next   = CW'(HDR_VERSION);
          state_next = S_HDR_RD;
        end else if (off + CW'(1) == count) begin
          // No pair found: keep only a trailing first magic byte.
          drop_en    = 1'b1;
          drop_n     = (rd_data == magic_first) ? count - CW'(1) : count;
          state_next = S_END;
        end else begin
          prev_byte_next = rd_data;
          off_next       = off + CW'(1);
          state_next     = S_SCAN_RD;
        end
      end
      S_HDR_RD: begin
        state_next = (CNT_W'(count) < CNT_W'(HEADER_BYTES)) ? S_END : S_HDR_CHK;
      end
      S_HDR_CHK: begin
        if (off != CW'(HDR_LEN_HI)) begin
          if (off == CW'(HDR_VERSION)) begin
            ver_next = rd_data;
          end else if (off == CW'(HDR_TYPE)) begin
            mt_next = rd_data;
          end else begin
            lo_byte_next = rd_data;
          end
          off_next   = off + CW'(1);
          state_next = S_HDR_RD;
        end else if (len_bad) begin
          if (pass) begin
            ek_next    = EK_LEN;
            state_next = S_EMIT;
          end else begin
            any_hit_next = 1'b1;
            drop_en      = 1'b1;
            drop_n       = CW'(1);
            off_next     = '0;
            state_next   = S_SCAN_RD;
          end
        end else if (CNT_W'(count) < flen_lo) begin
          state_next = S_END;
        end else begin
          plen_next = lo_byte[LEN_W-1:0];
          if (!pass) begin
            any_hit_next = 1'b1;
            drop_en      = 1'b1;
            drop_n       = CW'(flen_lo);
            off_next     = '0;
            state_next   = S_SCAN_RD;
          end else begin
            ek_next    = EK_PAY;
            pidx_next  = '0;
            pbyte_next = 8'd0;
            state_next = (lo_byte == 8'd0) ? S_EMIT : S_PAY_RD;
          end
        end
      end
      S_PAY_RD: begin
        state_next = S_PAY_CHK;
      end
      S_PAY_CHK: begin
        pbyte_next = rd_data;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!m_tvalid_q || m_tready) begin
          load_out = 1'b1;
          if (ek == EK_OVF) begin
            state_next = S_IDLE;
          end else if (ek == EK_LEN) begin
            drop_en    = 1'b1;
            drop_n     = CW'(1);
            off_next   = '0;
            state_next = S_SCAN_RD;
          end else if (plen == '0 || pidx + LEN_W'(1) == plen) begin
            drop_en    = 1'b1;
            drop_n     = CW'(flen_q);
            off_next   = '0;
            state_next = S_SCAN_RD;
          end else begin
            pidx_next  = pidx + LEN_W'(1);
            state_next = S_PAY_RD;
          end
        end
      end
      S_END: begin
        if (!pass && any_hit) begin
          // Replay the parse from the saved start, now knowing the final fill level.
          final_count_next = count;
          pass_next        = 1'b1;
          head_next        = save_head;
          count_next       = save_count;
          off_next         = '0;
          state_next       = S_SCAN_RD;
        end else begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (drop_en) begin
      head_next  = head_drop;
      count_next = count - drop_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      head       <= '0;
      pass       <= 1'b0;
      any_hit    <= 1'b0;
      m_tvalid_q <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      head    <= head_next;
      pass    <= pass_next;
      any_hit <= any_hit_next;
      if (load_out) begin
        m_tvalid_q <= 1'b1;
      end else if (m_tready) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    save_head   <= save_head_next;
    save_count  <= save_count_next;
    final_count <= final_count_next;
    off         <= off_next;
    prev_byte   <= prev_byte_next;
    ver         <= ver_next;
    mt          <= mt_next;
    lo_byte     <= lo_byte_next;
    pbyte       <= pbyte_next;
    plen        <= plen_next;
    pidx        <= pidx_next;
    ek          <= ek_next;
    if (load_out) begin
      out_q.pad            <= '0;
      out_q.buffered_count <= CNT_W'(final_count);
      if (ek == EK_PAY) begin
        m_tuser_q            <= RK_PAYLOAD;
        m_tlast_q            <= (plen == '0) || (pidx + LEN_W'(1) == plen);
        out_q.error_code     <= ERR_OVERFLOW;
        out_q.frame_version  <= ver;
        out_q.message_type   <= mt;
        out_q.payload_length <= plen;
        out_q.payload_index  <= pidx;
        out_q.payload_byte   <= pbyte;
      end else begin
        m_tuser_q            <= RK_ERROR;
        m_tlast_q            <= 1'b1;
        out_q.error_code     <= (ek == EK_LEN) ? ERR_LENGTH : ERR_OVERFLOW;
        out_q.frame_version  <= 8'd0;
        out_q.message_type   <= 8'd0;
        out_q.payload_length <= '0;
        out_q.payload_index  <= '0;
        out_q.payload_byte   <= 8'd0;
      end
    end
  end

  assign m_tvalid = m_tvalid_q;
  assign m_tdata  = out_q;
  assign m_tuser  = m_tuser_q;
  assign m_tlast  = m_tlast_q;

  // Configuration registers.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      magic_first  <= MAGIC_FIRST_RST;
      magic_second <= MAGIC_SECOND_RST;
      max_len      <= MAX_LEN_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        REG_MAGIC_FIRST:  magic_first  <= pwdata[7:0];
        REG_MAGIC_SECOND: magic_second <= pwdata[7:0];
        REG_MAX_LEN:      max_len      <= pwdata[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MAGIC_FIRST:  prdata = {24'd0, magic_first};
      REG_MAGIC_SECOND: prdata = {24'd0, magic_second};
      REG_MAX_LEN:      prdata = {26'd0, max_len};
      default:          prdata = 32'd0;
    endcase
  end

  `MLFD_ASSERT_IMPLIES(a_count_range, 1'b1, count <= CW'(BUFFER_BYTES), "fill level above buffer size")
  `MLFD_ASSERT_NEXT(a_clear_empties, accept && s_tuser == KIND_CLEAR, count == '0, "clear request left bytes in the ring")
  `MLFD_ASSERT_IMPLIES(a_error_fields, m_tvalid_q && m_tuser_q == RK_ERROR, m_tlast_q && out_q.payload_length == '0 && out_q.payload_index == '0, "error result carries frame fields")
  `MLFD_ASSERT_IMPLIES(a_index_in_frame, m_tvalid_q && m_tuser_q == RK_PAYLOAD && out_q.payload_length != '0, out_q.payload_index < out_q.payload_length && m_tlast_q == (out_q.payload_index + LEN_W'(1) == out_q.payload_length), "payload index outside frame or wrong last mark")

endmodule
